>>> rtl/core/fkp_pkg.sv
package fkp_pkg;

    localparam int NUM_KEYS  = 4;
    localparam int PIN_BITS  = 4;
    // Only keys that have a pin bit are ever scanned.
    localparam int SCAN_KEYS = (NUM_KEYS < PIN_BITS) ? NUM_KEYS : PIN_BITS;

    localparam int TICK_W   = 32;
    localparam int THRESH_W = 16;

    localparam logic [THRESH_W-1:0] SHORT_RESET = THRESH_W'(50);
    localparam logic [THRESH_W-1:0] LONG_RESET  = THRESH_W'(800);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_ADDR_W = 3;

    typedef enum logic [0:0] {
        REG_SHORT_TICKS = 1'b0,
        REG_LONG_TICKS  = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        KM_MCP = 2'd0,
        KM_LED = 2'd1,
        KM_DS  = 2'd2,
        KM_SEG = 2'd3
    } key_mode_t;

    typedef struct packed {
        logic [PIN_BITS-1:0] shorts;
        logic [PIN_BITS-1:0] longs;
    } evt_t;

    function automatic key_mode_t next_key_mode(key_mode_t m);
        key_mode_t r;
        unique case (m)
            KM_MCP:  r = KM_DS;
            KM_DS:   r = KM_SEG;
            KM_SEG:  r = KM_LED;
            KM_LED:  r = KM_MCP;
            default: r = KM_MCP;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/fkp_front.sv
module fkp_front
    import fkp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [PIN_BITS-1:0] pin_levels,
    input  logic [TICK_W-1:0]   now_tick,
    input  logic [THRESH_W-1:0] short_ticks,
    input  logic [THRESH_W-1:0] long_ticks,
    input  logic                q_full,
    output logic                push,
    output evt_t                push_evt
);

    logic [SCAN_KEYS-1:0] held_reg;
    logic [SCAN_KEYS-1:0] held_next;
    logic [TICK_W-1:0]    stamp_reg  [SCAN_KEYS];
    logic [TICK_W-1:0]    stamp_next [SCAN_KEYS];

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    // Each key is classified on its own: one subtract and two compares.
    always_comb
    begin
        logic [TICK_W-1:0] dt;
        held_next = held_reg;
        push_evt  = '0;
        dt        = '0;
        for (int i = 0; i < SCAN_KEYS; i++)
        begin
            stamp_next[i] = stamp_reg[i];
            dt = now_tick - stamp_reg[i];
            if (!pin_levels[i])
            begin
                if (!held_reg[i])
                begin
                    held_next[i]  = 1'b1;
                    stamp_next[i] = now_tick;
                end
            end
            else if (held_reg[i])
            begin
                held_next[i] = 1'b0;
                if (dt >= TICK_W'(long_ticks))
                    push_evt.longs[i] = 1'b1;
                else if (dt >= TICK_W'(short_ticks))
                    push_evt.shorts[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else if (push)
            held_reg <= held_next;
    end

    // A stamp is only read while its key is held, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int i = 0; i < SCAN_KEYS; i++)
                stamp_reg[i] <= stamp_next[i];
        end
    end

endmodule

>>> rtl/core/fkp_queue.sv
module fkp_queue
    import fkp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  evt_t push_evt,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output evt_t q_evt
);

    evt_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_evt   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_evt;
    end

endmodule

>>> rtl/core/fkp_back.sv
module fkp_back
    import fkp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  evt_t                q_evt,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PIN_BITS-1:0] short_events,
    output logic [PIN_BITS-1:0] long_events,
    output key_mode_t           key_mode,
    output logic                sys_mode
);

    logic      out_valid_reg;
    key_mode_t key_mode_reg;
    key_mode_t key_mode_next;
    logic      sys_mode_reg;
    logic      sys_mode_next;
    evt_t      evt_reg;

    // The output register is refilled in the same cycle that its beat leaves.
    assign pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        key_mode_next = q_evt.shorts[0] ? next_key_mode(key_mode_reg) : key_mode_reg;
        sys_mode_next = sys_mode_reg ^ q_evt.longs[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            key_mode_reg  <= KM_MCP;
            sys_mode_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                key_mode_reg  <= key_mode_next;
                sys_mode_reg  <= sys_mode_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            evt_reg <= q_evt;
    end

    assign out_valid    = out_valid_reg;
    assign short_events = evt_reg.shorts;
    assign long_events  = evt_reg.longs;
    assign key_mode     = key_mode_reg;
    assign sys_mode     = sys_mode_reg;

endmodule

>>> rtl/core/four_key_press_classifier.sv
// Channel    Direction  Contents
// s_axis     in         tdata: pin_levels[3:0], now_tick[35:4], zero fill [39:36]
// m_axis     out        tdata: short_events[3:0], long_events[7:4], key_mode[9:8],
//                              sys_mode[10], zero fill [15:11]
// apb        in/out     0x0 short_ticks, 0x4 long_ticks (16 bit each)
//
// One scan sample is taken per cycle while the event queue has room; its beat
// passes through the classifier into the event queue and then leaves from the
// output register. The two-entry event queue sets the input stall: s_axis_tready
// falls only once the queue is full behind a stalled output.
// Reset clears key state and modes and reloads the reset thresholds at once, with no sweep.
module four_key_press_classifier
    import fkp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,   // pin_levels, now_tick
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // short_events, long_events, key_mode, sys_mode
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [THRESH_W-1:0] short_ticks_reg;
    logic [THRESH_W-1:0] long_ticks_reg;
    reg_index_t          cfg_idx;
    logic                cfg_wr;

    logic                push;
    evt_t                push_evt;
    logic                q_full;
    logic                q_valid;
    logic                pop;
    evt_t                q_evt;

    logic [PIN_BITS-1:0] short_events;
    logic [PIN_BITS-1:0] long_events;
    key_mode_t           key_mode;
    logic                sys_mode;

    assign pready  = 1'b1;
    assign cfg_idx = reg_index_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_ticks_reg <= SHORT_RESET;
            long_ticks_reg  <= LONG_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SHORT_TICKS: short_ticks_reg <= pwdata[THRESH_W-1:0];
                REG_LONG_TICKS:  long_ticks_reg  <= pwdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SHORT_TICKS: prdata = 32'(short_ticks_reg);
            REG_LONG_TICKS:  prdata = 32'(long_ticks_reg);
            default:         prdata = '0;
        endcase
    end

    fkp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .pin_levels  (s_axis_tdata[PIN_BITS-1:0]),
        .now_tick    (s_axis_tdata[PIN_BITS +: TICK_W]),
        .short_ticks (short_ticks_reg),
        .long_ticks  (long_ticks_reg),
        .q_full      (q_full),
        .push        (push),
        .push_evt    (push_evt)
    );

    fkp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_evt (push_evt),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_evt    (q_evt)
    );

    fkp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_evt        (q_evt),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .short_events (short_events),
        .long_events  (long_events),
        .key_mode     (key_mode),
        .sys_mode     (sys_mode)
    );

    assign m_axis_tdata = {5'd0, sys_mode, key_mode, long_events, short_events};

endmodule

>>> tb/four_key_press_classifier_tb.sv
`timescale 1ns / 100ps

module four_key_press_classifier_tb;
    import fkp_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int NUM_SETTINGS    = 7;
    localparam int SCANS_PER_SET   = 190;
    localparam int PRESSURE_CYCLES = 180;
    localparam int NUM_ROWS        = 22;

    typedef struct packed {
        logic [3:0] shorts;
        logic [3:0] longs;
        key_mode_t  mode;
        logic       sys;
    } press_result_t;

    typedef struct packed {
        logic [3:0]    pins;
        logic [31:0]   tick;
        logic          typed;
        press_result_t res;
    } scan_row_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata   = '0;   // pin_levels[3:0], now_tick[35:4], zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [15:0] m_axis_tdata;          // short_events[3:0], long_events[7:4], key_mode[9:8],
                                        // sys_mode[10], zero fill
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;

    four_key_press_classifier dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Our own copy of the key state, thresholds and modes.
    logic [15:0] thr_short = SHORT_RESET;
    logic [15:0] thr_long  = LONG_RESET;
    logic        key_held  [4] = '{default: 1'b0};
    logic [31:0] key_stamp [4] = '{default: 32'd0};
    key_mode_t   mode_now  = KM_MCP;
    logic        sys_now   = 1'b0;

    press_result_t pending_results[$];
    press_result_t want;
    int mismatches     = 0;
    int beats_seen     = 0;
    int scans_sent     = 0;
    int short_releases = 0;
    int long_releases  = 0;
    int cycle_count    = 0;
    bit quiet_tx       = 1'b0;
    bit pressure_done  = 1'b0;

    // Directed scans. Only the opening rows, straight after reset, carry a typed result.
    scan_row_t scan_rows [NUM_ROWS] = '{
        '{4'hF, 32'd0,          1'b1, '{4'h0, 4'h0, KM_MCP, 1'b0}},
        '{4'h0, 32'd100,        1'b1, '{4'h0, 4'h0, KM_MCP, 1'b0}},
        '{4'h0, 32'd120,        1'b1, '{4'h0, 4'h0, KM_MCP, 1'b0}},
        '{4'h1, 32'd149,        1'b1, '{4'h0, 4'h0, KM_MCP, 1'b0}},
        '{4'hF, 32'd150,        1'b1, '{4'hE, 4'h0, KM_MCP, 1'b0}},
        '{4'hE, 32'd1000,       1'b0, '0},
        '{4'hF, 32'd1050,       1'b0, '0},
        '{4'hE, 32'd2000,       1'b0, '0},
        '{4'hF, 32'd2799,       1'b0, '0},
        '{4'hE, 32'd3000,       1'b0, '0},
        '{4'hF, 32'd3800,       1'b0, '0},
        '{4'hE, 32'd4000,       1'b0, '0},
        '{4'hF, 32'd4050,       1'b0, '0},
        '{4'hE, 32'd5000,       1'b0, '0},
        '{4'hF, 32'd5050,       1'b0, '0},
        '{4'h0, 32'hFFFF_FFF0,  1'b0, '0},
        '{4'hF, 32'h0000_0310,  1'b0, '0},
        '{4'h0, 32'hFFFF_FFFF,  1'b0, '0},
        '{4'hF, 32'hFFFF_FFFF,  1'b0, '0},
        '{4'h5, 32'h5555_5555,  1'b0, '0},
        '{4'hA, 32'hAAAA_AAAA,  1'b0, '0},
        '{4'hF, 32'hAAAA_ABEC,  1'b0, '0}
    };

    // Threshold settings for the random part; the first is the reset setting.
    logic [15:0] set_short [NUM_SETTINGS] = '{16'd50,  16'd0, 16'hFFFF, 16'd900,
                                              16'd3,   16'd0, 16'hFFFF};
    logic [15:0] set_long  [NUM_SETTINGS] = '{16'd800, 16'd0, 16'hFFFF, 16'd300,
                                              16'd12,  16'hFFFF, 16'd0};

    function automatic press_result_t classify_scan(logic [3:0] pins, logic [31:0] tick);
        press_result_t r;
        logic [31:0]   held_for;
        r = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (!pins[i])
            begin
                if (!key_held[i])
                begin
                    key_held[i]  = 1'b1;
                    key_stamp[i] = tick;
                end
            end
            else if (key_held[i])
            begin
                held_for    = tick - key_stamp[i];
                key_held[i] = 1'b0;
                // The long test wins whenever both thresholds are met.
                if (held_for >= {16'd0, thr_long})
                    r.longs[i] = 1'b1;
                else if (held_for >= {16'd0, thr_short})
                    r.shorts[i] = 1'b1;
            end
        end
        if (r.shorts[0])
        begin
            case (mode_now)
                KM_MCP:  mode_now = KM_DS;
                KM_DS:   mode_now = KM_SEG;
                KM_SEG:  mode_now = KM_LED;
                default: mode_now = KM_MCP;
            endcase
        end
        if (r.longs[0])
            sys_now = ~sys_now;
        r.mode = mode_now;
        r.sys  = sys_now;
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch at beat %0d: %s expected %0h, got %0h",
                     beats_seen, what, want_v, got_v);
    endtask

    task automatic send_scan(logic [3:0] pins, logic [31:0] tick, logic typed,
                             press_result_t typed_res);
        int            gap;
        int            r;
        press_result_t res;
        gap = 0;
        if (!quiet_tx)
        begin
            r = $urandom_range(0, 99);
            if (r >= 98)
                gap = $urandom_range(20, 60);
            else if (r >= 90)
                gap = $urandom_range(4, 10);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, tick, pins};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = classify_scan(pins, tick);
        pending_results.push_back(typed ? typed_res : res);
        scans_sent++;
        if (scans_sent % 40 == 0)
            quiet_tx = ($urandom_range(0, 3) == 0);
    endtask

    // Returns once every expected beat has come out and the pipeline has drained.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(reg_index_t idx, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx == REG_SHORT_TICKS)
            thr_short = value;
        else
            thr_long = value;
    endtask

    task automatic check_register(reg_index_t idx, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {16'd0, value})
            note_mismatch(idx == REG_SHORT_TICKS ? "short_ticks read" : "long_ticks read",
                          {16'd0, value}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed press and release sequences, with some releases aimed
    // exactly at the thresholds and a little noise in the pins and the tick.
    task automatic press_release_run(int count);
        int          r;
        int          k;
        int          b;
        int          span;
        logic [3:0]  pins;
        logic [31:0] tick;
        logic [31:0] hold;
        pins = 4'hF;
        tick = $urandom;
        span = ((thr_short > thr_long) ? int'(thr_short) : int'(thr_long)) / 3 + 2;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                pins = 4'($urandom);
                tick = $urandom;
            end
            else if (r < 25)
            begin
                k = $urandom_range(0, 3);
                if (key_held[k])
                begin
                    case ($urandom_range(0, 4))
                        0:       hold = {16'd0, thr_short} - 32'd1;
                        1:       hold = {16'd0, thr_short};
                        2:       hold = {16'd0, thr_long} - 32'd1;
                        3:       hold = {16'd0, thr_long};
                        default: hold = $urandom_range(0, span);
                    endcase
                    tick    = key_stamp[k] + hold;
                    pins[k] = 1'b1;
                end
                else
                begin
                    tick    = tick + $urandom_range(0, 3);
                    pins[k] = 1'b0;
                end
            end
            else
            begin
                tick = tick + $urandom_range(0, span);
                for (b = 0; b < 4; b++)
                    if ($urandom_range(0, 2) == 0)
                        pins[b] = ~pins[b];
            end
            send_scan(pins, tick, 1'b0, '0);
        end
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_seen++;
            short_releases += $countones(m_axis_tdata[3:0]);
            long_releases  += $countones(m_axis_tdata[7:4]);
            if (pending_results.size() == 0)
                note_mismatch("unexpected beat", 32'd0, {16'd0, m_axis_tdata});
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[3:0] !== want.shorts)
                    note_mismatch("short_events", 32'(want.shorts), 32'(m_axis_tdata[3:0]));
                if (m_axis_tdata[7:4] !== want.longs)
                    note_mismatch("long_events", 32'(want.longs), 32'(m_axis_tdata[7:4]));
                if (m_axis_tdata[9:8] !== want.mode)
                    note_mismatch("key_mode", 32'(want.mode), 32'(m_axis_tdata[9:8]));
                if (m_axis_tdata[10] !== want.sys)
                    note_mismatch("sys_mode", 32'(want.sys), 32'(m_axis_tdata[10]));
            end
        end
    end

    // Receiver: random stalls, quiet windows, and one long hold-off to back the block up.
    initial
    begin : receiver
        int r;
        int window;
        int hold_left;
        window    = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            window++;
            if (window == 64)
                window = 0;
            if (!pressure_done && scans_sent >= 300)
            begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (window < 16)
                m_axis_tready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    m_axis_tready <= 1'b1;
                else if (r < 97)
                    m_axis_tready <= 1'b0;
                else
                begin
                    hold_left     = $urandom_range(10, 40);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d beats outstanding",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_register(REG_SHORT_TICKS, SHORT_RESET);
        check_register(REG_LONG_TICKS, LONG_RESET);

        for (int i = 0; i < NUM_ROWS; i++)
            send_scan(scan_rows[i].pins, scan_rows[i].tick, scan_rows[i].typed,
                      scan_rows[i].res);

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            if (s > 0)
            begin
                wait_idle();
                write_register(REG_SHORT_TICKS, set_short[s]);
                write_register(REG_LONG_TICKS, set_long[s]);
                check_register(REG_SHORT_TICKS, set_short[s]);
                check_register(REG_LONG_TICKS, set_long[s]);
            end
            press_release_run(SCANS_PER_SET);
        end

        wait_idle();
        repeat (8) @(posedge clk);

        $display("Run covered %0d scan samples and %0d result beats over %0d threshold settings.",
                 scans_sent, beats_seen, NUM_SETTINGS);
        $display("Releases reported: %0d short and %0d long; %0d mismatches.",
                 short_releases, long_releases, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
